// ===== rtl/caarf_pkg.sv =====
// ----------------------------------------------------------------------------
// caarf_pkg
// shared types, constants and helpers for the coverage antialias resolve
// ----------------------------------------------------------------------------
package caarf_pkg;

    localparam int unsigned TILE_WIDTH_DEF = 64;
    localparam int unsigned COLOR_W        = 16;
    localparam int unsigned COV_W          = 8;
    localparam int unsigned CHAN_W         = 8;
    localparam logic [COV_W-1:0] COV_FULL  = 8'hFF;

    // apb register map
    localparam int unsigned APB_AW         = 3;
    localparam int unsigned APB_DW         = 32;
    localparam logic [0:0]  REG_ENABLE     = 1'b0;

    // one pending resolve: centre pixel and its original neighbor taps
    typedef struct packed {
        logic [COLOR_W-1:0] centre;
        logic [COV_W-1:0]   cov;
        logic               has_l;
        logic [COLOR_W-1:0] left;
        logic               has_r;
        logic [COLOR_W-1:0] right;
        logic               last_of_run;
    } t_job;

    typedef logic [2:0][CHAN_W-1:0] t_rgb8;

    // rgb565 to 8 bits per channel by bit replication
    function automatic t_rgb8 unpack_rgb(input logic [COLOR_W-1:0] px);
        t_rgb8 ch;
        ch[0] = {px[15:11], px[15:13]};
        ch[1] = {px[10:5], px[10:9]};
        ch[2] = {px[4:0], px[4:2]};
        return ch;
    endfunction

endpackage

// ===== rtl/caarf_ifs.sv =====
// ----------------------------------------------------------------------------
// caarf channel interfaces
// valid/ready pixel input channel and resolved result channel
// ----------------------------------------------------------------------------
interface caarf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic [7:0]  coverage;

    modport source(output valid, pixel_color, coverage, input ready);
    modport sink(input valid, pixel_color, coverage, output ready);
endinterface

interface caarf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] resolved_color;
    logic        last_of_run;

    modport source(output valid, resolved_color, last_of_run, input ready);
    modport sink(input valid, resolved_color, last_of_run, output ready);
endinterface

// ===== rtl/caarf_resolve.sv =====
// ----------------------------------------------------------------------------
// caarf_resolve
// per-pixel blend toward the neighbor min/max, weighted by missing coverage
// ----------------------------------------------------------------------------
module caarf_resolve (
    input  caarf_pkg::t_job             i_job,
    input  logic                        i_enable,
    output logic [caarf_pkg::COLOR_W-1:0] o_color
);
    import caarf_pkg::*;

    t_rgb8              c_rgb;
    t_rgb8              l_rgb;
    t_rgb8              r_rgb;
    t_rgb8              mn;
    t_rgb8              mx;
    t_rgb8              res;
    logic [COV_W-1:0]   weight;
    logic signed [10:0] diff  [3];
    logic signed [19:0] prod  [3];
    logic signed [11:0] total [3];

    always_comb begin
        c_rgb  = unpack_rgb(i_job.centre);
        l_rgb  = unpack_rgb(i_job.left);
        r_rgb  = unpack_rgb(i_job.right);
        weight = COV_FULL - i_job.cov;
        for (int i = 0; i < 3; i++) begin
            mn[i] = c_rgb[i];
            mx[i] = c_rgb[i];
            if (i_job.has_l) begin
                if (l_rgb[i] < mn[i]) mn[i] = l_rgb[i];
                if (l_rgb[i] > mx[i]) mx[i] = l_rgb[i];
            end
            if (i_job.has_r) begin
                if (r_rgb[i] < mn[i]) mn[i] = r_rgb[i];
                if (r_rgb[i] > mx[i]) mx[i] = r_rgb[i];
            end
            diff[i]  = $signed({3'b000, mn[i]}) + $signed({3'b000, mx[i]})
                     - $signed({2'b00, c_rgb[i], 1'b0});
            prod[i]  = 20'(diff[i]) * 20'($signed({1'b0, weight}));
            // upper bits of the product are the floor shift by 8
            total[i] = $signed({4'b0000, c_rgb[i]}) + $signed(prod[i][19:8]);
            if (total[i] < 0) begin
                res[i] = '0;
            end else if (total[i] > 12'sd255) begin
                res[i] = 8'hFF;
            end else begin
                res[i] = total[i][7:0];
            end
        end
        if (!i_enable || (i_job.cov == COV_FULL)) begin
            o_color = i_job.centre;
        end else begin
            o_color = {res[0][7:3], res[1][7:2], res[2][7:3]};
        end
    end

endmodule

// ===== rtl/coverage_aa_resolve_filter.sv =====
// ----------------------------------------------------------------------------
// coverage_aa_resolve_filter
// row-streamed coverage antialias resolve with an apb enable register
// ----------------------------------------------------------------------------
// path: after the transfer of the pixel that completes it, a result passes
// through the job register, then the result register
// throughput: one pixel per cycle unless the output stalls; the row-end pixel
// holds off the next one as its two results share the single resolve unit
// reset: synchronous active-low, clears column, held pixels, pipeline valids
// and the enable register (blend off)
module coverage_aa_resolve_filter #(
    parameter int unsigned TILE_WIDTH = caarf_pkg::TILE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    caarf_in_if.sink                      i_pix,
    caarf_out_if.source                   o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [caarf_pkg::APB_AW-1:0]  paddr,
    input  logic [caarf_pkg::APB_DW-1:0]  pwdata,
    output logic [caarf_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import caarf_pkg::*;

    localparam int unsigned COL_W = $clog2(TILE_WIDTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_WIDTH - 1);

    // configuration
    logic r_enable, n_enable;
    logic cfg_wr;

    // row state
    logic [COL_W-1:0]   r_col, n_col;
    logic [COLOR_W-1:0] r_held, n_held;
    logic [COV_W-1:0]   r_held_cov, n_held_cov;
    logic [COLOR_W-1:0] r_left, n_left;

    // job stage: slot 0 feeds the resolve unit, slot 1 holds the row-end extra
    t_job r_j0, n_j0, r_j1, n_j1;
    logic r_j0_v, n_j0_v, r_j1_v, n_j1_v;
    t_job new0, new1;

    // result register
    logic               r_out_v, n_out_v;
    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic               r_out_last, n_out_last;
    logic [COLOR_W-1:0] res_color;

    logic adv;       // slot 0 moves into the result register
    logic acc;       // input transfer this cycle
    logic col_first;
    logic col_last;

    // apb: always ready, one register at the bottom word
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ENABLE) ? {{(APB_DW-1){1'b0}}, r_enable} : '0;

    always_comb begin
        n_enable = r_enable;
        if (cfg_wr && (paddr[2] == REG_ENABLE)) begin
            n_enable = pwdata[0];
        end
    end

    // handshake: a free job stage, or one that empties this cycle with no extra
    assign adv         = r_j0_v && (!r_out_v || o_res.ready);
    assign i_pix.ready = !r_j0_v || (adv && !r_j1_v);
    assign acc         = i_pix.valid && i_pix.ready;
    assign col_first   = (r_col == '0);
    assign col_last    = (r_col == COL_LAST);

    // jobs created by the incoming pixel
    always_comb begin
        // held pixel, right tap is the new pixel
        new0.centre      = r_held;
        new0.cov         = r_held_cov;
        new0.has_l       = (r_col > COL_W'(1));
        new0.left        = r_left;
        new0.has_r       = 1'b1;
        new0.right       = i_pix.pixel_color;
        new0.last_of_run = !col_last;
        // row end: the new pixel itself, no right tap
        new1.centre      = i_pix.pixel_color;
        new1.cov         = i_pix.coverage;
        new1.has_l       = 1'b1;
        new1.left        = r_held;
        new1.has_r       = 1'b0;
        new1.right       = '0;
        new1.last_of_run = 1'b1;
    end

    // row state update
    always_comb begin
        n_col      = r_col;
        n_held     = r_held;
        n_held_cov = r_held_cov;
        n_left     = r_left;
        if (acc) begin
            n_held     = i_pix.pixel_color;
            n_held_cov = i_pix.coverage;
            if (col_first) begin
                n_col = COL_W'(1);
            end else begin
                n_left = r_held;
                n_col  = col_last ? '0 : r_col + COL_W'(1);
            end
        end
    end

    // job stage
    always_comb begin
        n_j0   = r_j0;
        n_j1   = r_j1;
        n_j0_v = r_j0_v;
        n_j1_v = r_j1_v;
        if (adv && r_j1_v) begin
            n_j0   = r_j1;
            n_j0_v = 1'b1;
            n_j1_v = 1'b0;
        end else if (adv || !r_j0_v) begin
            n_j0   = new0;
            n_j1   = new1;
            n_j0_v = acc && !col_first;
            n_j1_v = acc && col_last;
        end
    end

    caarf_resolve u_resolve (
        .i_job    (r_j0),
        .i_enable (r_enable),
        .o_color  (res_color)
    );

    // result register
    always_comb begin
        n_out_v     = r_out_v;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_v     = 1'b1;
            n_out_color = res_color;
            n_out_last  = r_j0.last_of_run;
        end else if (o_res.ready) begin
            n_out_v = 1'b0;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.resolved_color = r_out_color;
    assign o_res.last_of_run    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_col      <= '0;
            r_held     <= '0;
            r_held_cov <= '0;
            r_left     <= '0;
            r_j0_v     <= 1'b0;
            r_j1_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_enable   <= n_enable;
            r_col      <= n_col;
            r_held     <= n_held;
            r_held_cov <= n_held_cov;
            r_left     <= n_left;
            r_j0_v     <= n_j0_v;
            r_j1_v     <= n_j1_v;
            r_out_v    <= n_out_v;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_j0        <= n_j0;
        r_j1        <= n_j1;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

`ifndef NO_ASSERTIONS
    // the row-end extra never waits without the job in front of it
    a_j1_needs_j0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j1_v |-> r_j0_v)
        else $error("extra job pending with empty slot 0");

    // no transfer while the row-end extra is still queued
    a_j1_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j1_v |-> !i_pix.ready)
        else $error("input ready while extra job pending");

    // the job ahead of the row-end extra is never marked last
    a_j1_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j1_v |-> !r_j0.last_of_run)
        else $error("job before row-end extra flagged last");

    // a row-end transfer queues two results and wraps the column
    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && col_last) |=> (r_j1_v && (r_col == '0)))
        else $error("row end did not queue extra result");

    // column stays inside the tile row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("column index out of range");
`endif

endmodule
